>>> rtl/ffpa_pkg.sv
`default_nettype none

package ffpa_pkg;

  localparam int NUM_PARTITIONS_DEF  = 256;
  localparam int PARTITION_BYTES_DEF = 10;

  // Largest request_bytes value the input field can carry.
  localparam int BYTES_MAX = 4095;

  localparam int BYTES_W  = 12;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 3;
  localparam int START_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int WASTE_W  = 4;
  localparam int FREE_W   = 9;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_ROOM   = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic mark;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic found;
    logic mark_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/ffpa_datapath.sv
`default_nettype none

module ffpa_datapath
  import ffpa_pkg::*;
#(
  parameter int NUM_PARTITIONS  = NUM_PARTITIONS_DEF,
  parameter int PARTITION_BYTES = PARTITION_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctrl_cmd_t          cmd,
  output      dp_status_t         sts,
  input  wire logic               in_func,
  input  wire logic [BYTES_W-1:0] in_request_bytes,
  input  wire logic [ID_W-1:0]    in_free_id,
  output      status_t            res_status,
  output      logic [START_W-1:0] res_start_index,
  output      logic [COUNT_W-1:0] res_partition_count,
  output      logic [ID_W-1:0]    res_owner_id,
  output      logic [WASTE_W-1:0] res_waste_bytes,
  output      logic [FREE_W-1:0]  res_free_partitions
);

  localparam int IDX_W = $clog2(NUM_PARTITIONS);
  localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
  localparam int RUN_W = $clog2(BYTES_MAX + PARTITION_BYTES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTITIONS - 1);
  localparam logic [CNT_W-1:0] NUM_CNT  = CNT_W'(NUM_PARTITIONS);
  localparam logic [RUN_W-1:0] PB_RUN   = RUN_W'(PARTITION_BYTES);

  // Owner table: one write port, one registered read port.
  logic [ID_W-1:0] mem [NUM_PARTITIONS];

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ID_W-1:0]  mem_wdata;

  logic [IDX_W-1:0] clr_idx_r;
  logic [IDX_W-1:0] iss_idx_r;
  logic             iss_done_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [ID_W-1:0]  rd_data_r;
  logic             scan_done_r;
  logic             found_r;

  logic               func_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [ID_W-1:0]    fid_r;
  logic [CNT_W-1:0]   run_cnt_r;
  logic [RUN_W-1:0]   run_bytes_r;
  logic [IDX_W-1:0]   start_r;
  logic [IDX_W-1:0]   end_r;
  logic [IDX_W-1:0]   mark_idx_r;
  logic [CNT_W-1:0]   freed_cnt_r;

  logic [CNT_W-1:0] free_total_r;
  logic [CNT_W-1:0] free_total_nxt;
  logic [ID_W-1:0]  next_id_r;
  logic [ID_W-1:0]  next_id_nxt;
  logic [ID_W-1:0]  next_id_inc;

  status_t            out_status_r;
  logic [START_W-1:0] out_start_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [ID_W-1:0]    out_id_r;
  logic [WASTE_W-1:0] out_waste_r;
  logic [FREE_W-1:0]  out_free_r;

  logic             scan_act;
  logic             rd_en;
  logic             proc;
  logic             entry_free;
  logic [RUN_W-1:0] run_bytes_sum;
  logic             hit_alloc;
  logic             match_free;
  logic             last_rd;
  logic             alloc_ok;
  logic             free_ok;
  status_t          status_nxt;

  assign scan_act      = cmd.scan && !scan_done_r;
  assign rd_en         = scan_act && !iss_done_r;
  assign proc          = scan_act && rd_vld_r;
  assign entry_free    = (rd_data_r == ID_W'(0));
  assign run_bytes_sum = run_bytes_r + PB_RUN;
  assign last_rd       = (rd_idx_r == LAST_IDX);
  // The run is long enough once its bytes cover the request, which also
  // rules out requests larger than the whole table.
  assign hit_alloc  = proc && (func_r == FUNC_ALLOC) && entry_free &&
                      (run_bytes_sum >= RUN_W'(bytes_r));
  assign match_free = proc && (func_r == FUNC_FREE) && (fid_r != ID_W'(0)) &&
                      (rd_data_r == fid_r);

  assign alloc_ok = (func_r == FUNC_ALLOC) && found_r;
  assign free_ok  = (func_r == FUNC_FREE) && (freed_cnt_r != CNT_W'(0));

  assign next_id_inc = next_id_r + ID_W'(1);
  assign next_id_nxt = (next_id_inc == ID_W'(0)) ? ID_W'(1) : next_id_inc;

  always_comb begin
    free_total_nxt = free_total_r;
    if (alloc_ok) begin
      free_total_nxt = free_total_r - run_cnt_r;
    end else if (free_ok) begin
      free_total_nxt = free_total_r + freed_cnt_r;
    end
  end

  always_comb begin
    priority if (func_r == FUNC_FREE) begin
      status_nxt = free_ok ? ST_FREED : ST_NOT_FOUND;
    end else if (bytes_r == BYTES_W'(0)) begin
      status_nxt = ST_BAD_SIZE;
    end else if (found_r) begin
      status_nxt = ST_ALLOCATED;
    end else begin
      status_nxt = ST_NO_ROOM;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = ID_W'(0);
    priority if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (match_free) begin
      mem_we    = 1'b1;
      mem_waddr = rd_idx_r;
    end else if (cmd.mark) begin
      mem_we    = 1'b1;
      mem_waddr = mark_idx_r;
      mem_wdata = next_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[iss_idx_r];
      rd_idx_r  <= iss_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r    <= '0;
      iss_idx_r    <= '0;
      iss_done_r   <= 1'b0;
      rd_vld_r     <= 1'b0;
      scan_done_r  <= 1'b0;
      found_r      <= 1'b0;
      free_total_r <= NUM_CNT;
      next_id_r    <= ID_W'(1);
    end else begin
      if (cmd.clear) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (cmd.load) begin
        iss_idx_r   <= '0;
        iss_done_r  <= 1'b0;
        rd_vld_r    <= 1'b0;
        found_r     <= 1'b0;
        scan_done_r <= (in_func == FUNC_ALLOC) && (in_request_bytes == BYTES_W'(0));
      end else begin
        rd_vld_r <= rd_en;
        if (rd_en) begin
          iss_idx_r <= iss_idx_r + IDX_W'(1);
          if (iss_idx_r == LAST_IDX) begin
            iss_done_r <= 1'b1;
          end
        end
        if (hit_alloc) begin
          found_r     <= 1'b1;
          scan_done_r <= 1'b1;
        end else if (proc && last_rd) begin
          scan_done_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        free_total_r <= free_total_nxt;
        if (alloc_ok) begin
          next_id_r <= next_id_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r      <= in_func;
      bytes_r     <= in_request_bytes;
      fid_r       <= in_free_id;
      run_cnt_r   <= '0;
      run_bytes_r <= '0;
      freed_cnt_r <= '0;
    end else if (proc && (func_r == FUNC_ALLOC)) begin
      if (entry_free) begin
        if (run_cnt_r == CNT_W'(0)) begin
          start_r    <= rd_idx_r;
          mark_idx_r <= rd_idx_r;
        end
        run_cnt_r   <= run_cnt_r + CNT_W'(1);
        run_bytes_r <= run_bytes_sum;
        if (hit_alloc) begin
          end_r <= rd_idx_r;
        end
      end else begin
        run_cnt_r   <= '0;
        run_bytes_r <= '0;
      end
    end else if (match_free) begin
      freed_cnt_r <= freed_cnt_r + CNT_W'(1);
    end else if (cmd.mark) begin
      mark_idx_r <= mark_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_nxt;
      out_free_r   <= FREE_W'(free_total_nxt);
      out_start_r  <= '0;
      out_count_r  <= '0;
      out_id_r     <= '0;
      out_waste_r  <= '0;
      if (alloc_ok) begin
        out_start_r <= START_W'(start_r);
        out_count_r <= COUNT_W'(run_cnt_r);
        out_id_r    <= next_id_r;
        out_waste_r <= WASTE_W'(run_bytes_r - RUN_W'(bytes_r));
      end else if (free_ok) begin
        out_count_r <= COUNT_W'(freed_cnt_r);
        out_id_r    <= fid_r;
      end
    end
  end

  assign sts.clear_last = (clr_idx_r == LAST_IDX);
  assign sts.scan_done  = scan_done_r;
  assign sts.found      = found_r;
  assign sts.mark_last  = (mark_idx_r == end_r);

  assign res_status          = out_status_r;
  assign res_start_index     = out_start_r;
  assign res_partition_count = out_count_r;
  assign res_owner_id        = out_id_r;
  assign res_waste_bytes     = out_waste_r;
  assign res_free_partitions = out_free_r;

  a_found_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> scan_done_r)
    else $error("run found while scan still marked active");

  a_free_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= NUM_CNT)
    else $error("free partition total exceeds table size");

  a_next_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != ID_W'(0))
    else $error("id counter reached zero");

  a_mark_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> (found_r && mark_idx_r >= start_r && mark_idx_r <= end_r))
    else $error("marking outside the granted run");

endmodule

`default_nettype wire

>>> rtl/ffpa_controller.sv
`default_nettype none

module ffpa_controller
  import ffpa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      ctrl_cmd_t  cmd,
  input  wire dp_status_t sts
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MARK  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // The result register can be loaded once its previous result has moved on.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sts.found ? S_MARK : S_RESP;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/first_fit_partition_allocator.sv
`default_nettype none

// First-fit allocator over a table of NUM_PARTITIONS partitions of
// PARTITION_BYTES bytes each. After reset the owner table is cleared by a
// pass that writes one entry per cycle, and the input stays not ready until
// the pass ends. One request is handled at a time. An allocate is loaded, then
// scans the table one entry per cycle through the single read port of the
// owner table until the first fitting run ends, then writes the new id into
// the run at one partition per cycle, then posts the result once the output
// register is free. A rejected size skips the scan. A free always scans the
// whole table, clearing matches on the fly. The result sits in an output
// register, and the next request is accepted while it waits to be taken.
module first_fit_partition_allocator
  import ffpa_pkg::*;
#(
  parameter int NUM_PARTITIONS  = NUM_PARTITIONS_DEF,
  parameter int PARTITION_BYTES = PARTITION_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_func,
  input  wire logic [BYTES_W-1:0] in_request_bytes,
  input  wire logic [ID_W-1:0]    in_free_id,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [STATUS_W-1:0] out_status,
  output      logic [START_W-1:0] out_start_index,
  output      logic [COUNT_W-1:0] out_partition_count,
  output      logic [ID_W-1:0]    out_owner_id,
  output      logic [WASTE_W-1:0] out_waste_bytes,
  output      logic [FREE_W-1:0]  out_free_partitions
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  status_t    res_status;

  ffpa_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffpa_datapath #(
    .NUM_PARTITIONS  (NUM_PARTITIONS),
    .PARTITION_BYTES (PARTITION_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_func),
    .in_request_bytes    (in_request_bytes),
    .in_free_id          (in_free_id),
    .res_status          (res_status),
    .res_start_index     (out_start_index),
    .res_partition_count (out_partition_count),
    .res_owner_id        (out_owner_id),
    .res_waste_bytes     (out_waste_bytes),
    .res_free_partitions (out_free_partitions)
  );

  assign out_status = res_status;

endmodule

`default_nettype wire
